### hw/rtl/scsp_pkg.sv
// Shared types and constants of the song container stream parser.
// No dependencies.
package scsp_pkg;

  localparam int unsigned HEADER_LEN = 26;

  localparam logic [7:0] MAGIC [4] = '{8'h4F, 8'h43, 8'h53, 8'h47};

  localparam logic [11:0] FRAME_A = 12'd960;
  localparam logic [11:0] FRAME_B = 12'd1920;
  localparam logic [11:0] FRAME_C = 12'd2880;

  localparam logic [2:0] REG_MAX_BYTES   = 3'd0;
  localparam logic [2:0] REG_MAX_TOTAL   = 3'd1;
  localparam logic [2:0] REG_MAX_SKIP    = 3'd2;
  localparam logic [2:0] REG_MAX_PACKET  = 3'd3;
  localparam logic [2:0] REG_MIN_GAIN    = 3'd4;
  localparam logic [2:0] REG_SAMPLE_RATE = 3'd5;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_LENGTH  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  localparam logic [1:0] ST_RUN      = 2'd0;
  localparam logic [1:0] ST_ACCEPTED = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;

  localparam logic [3:0] E_NONE      = 4'd0;
  localparam logic [3:0] E_SHORT     = 4'd1;
  localparam logic [3:0] E_OVERSIZE  = 4'd2;
  localparam logic [3:0] E_MAGIC     = 4'd3;
  localparam logic [3:0] E_VERSION   = 4'd4;
  localparam logic [3:0] E_CHANNELS  = 4'd5;
  localparam logic [3:0] E_RESERVED  = 4'd6;
  localparam logic [3:0] E_RATE      = 4'd7;
  localparam logic [3:0] E_LIMITS    = 4'd8;
  localparam logic [3:0] E_COUNT     = 4'd9;
  localparam logic [3:0] E_LENGTH    = 4'd10;
  localparam logic [3:0] E_TRUNCATED = 4'd11;
  localparam logic [3:0] E_TRAILING  = 4'd12;

  typedef struct packed {
    logic step;
    logic use_held;
    logic capture;
    logic mul;
  } cmd_t;

  typedef struct packed {
    logic count_byte;
  } stat_t;

  function automatic logic frame_ok(input logic [15:0] f);
    return f == {4'd0, FRAME_A} || f == {4'd0, FRAME_B} || f == {4'd0, FRAME_C};
  endfunction

endpackage

### hw/rtl/scsp_byte_if.sv
// Input byte channel of the parser.
// No dependencies.
interface scsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;
  modport source (output valid, data_byte, last, input ready);
  modport sink (input valid, data_byte, last, output ready);
endinterface

### hw/rtl/scsp_res_if.sv
// Result channel of the parser, one transfer per input byte.
// No dependencies.
interface scsp_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         byte_kind;
  logic [7:0]         payload_byte;
  logic               packet_end;
  logic               header_done;
  logic [1:0]         channel_count;
  logic [11:0]        frame_size;
  logic [15:0]        skip_samples;
  logic [31:0]        sample_total;
  logic signed [15:0] gain;
  logic [31:0]        packet_total;
  logic [1:0]         status;
  logic [3:0]         error_code;
  modport source (output valid, byte_kind, payload_byte, packet_end, header_done,
    channel_count, frame_size, skip_samples, sample_total, gain, packet_total,
    status, error_code, input ready);
  modport sink (input valid, byte_kind, payload_byte, packet_end, header_done,
    channel_count, frame_size, skip_samples, sample_total, gain, packet_total,
    status, error_code, output ready);
endinterface

### hw/rtl/scsp_cfg_if.sv
// Configuration write channel of the parser.
// No dependencies.
interface scsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/scsp_dpath.sv
// Parser datapath: config registers, container state, count check multipliers,
// result register. Depends on scsp_pkg.
module scsp_dpath
  import scsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              st,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic [1:0]         byte_kind,
  output logic [7:0]         payload_byte,
  output logic               packet_end,
  output logic               header_done,
  output logic [1:0]         channel_count,
  output logic [11:0]        frame_size,
  output logic [15:0]        skip_samples,
  output logic [31:0]        sample_total,
  output logic signed [15:0] gain,
  output logic [31:0]        packet_total,
  output logic [1:0]         status,
  output logic [3:0]         error_code
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_DONE, PH_ERROR
  } phase_t;

  logic [31:0] max_bytes, max_total, rate;
  logic [15:0] max_skip, max_pkt;
  logic signed [15:0] min_gain;

  phase_t      phase, phase_next;
  logic [31:0] pos, pos_next;
  logic [1:0]  ch, ch_next;
  logic [15:0] fr, fr_next, sk, sk_next, gn, gn_next, pl, pl_next;
  logic [31:0] tot, tot_next, cnt, cnt_next, pk, pk_next;
  logic [7:0]  llo, llo_next;
  logic [3:0]  ferr, ferr_next;

  logic [7:0]  hb;
  logic        hl;
  logic [43:0] p1, p2;
  logic [32:0] nsum;
  logic        c_lt2, fr_good;

  logic [7:0]  b;
  logic        lst, cnt_ok;
  logic [31:0] pos_inc, c_full;
  logic [4:0]  idx;
  logic [1:0]  kind;
  logic [3:0]  err;
  logic [1:0]  stat;
  logic        pend, hd, show;
  logic [15:0] len;
  logic signed [15:0] g;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= 32'd1048576;
      max_total <= 32'd14424000;
      max_skip  <= 16'd3840;
      max_pkt   <= 16'd1275;
      min_gain  <= -16'sd32768;
      rate      <= 32'd48000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_BYTES:   max_bytes <= cfg_data;
        REG_MAX_TOTAL:   max_total <= cfg_data;
        REG_MAX_SKIP:    max_skip  <= cfg_data[15:0];
        REG_MAX_PACKET:  max_pkt   <= cfg_data[15:0];
        REG_MIN_GAIN:    min_gain  <= cfg_data[15:0];
        REG_SAMPLE_RATE: rate      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign st.count_byte = phase == PH_HEADER && pos == 32'd25;

  assign c_full = cnt | {hb, 24'd0};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hb <= in_byte;
      hl <= in_last;
    end
    if (cmd.mul) begin
      p1      <= c_full * fr[11:0];
      p2      <= (c_full - 32'd2) * fr[11:0];
      nsum    <= {1'b0, tot} + {17'd0, sk};
      c_lt2   <= c_full < 32'd2;
      fr_good <= frame_ok(fr);
    end
  end

  assign cnt_ok = fr_good && {11'd0, nsum} <= p1 && (c_lt2 || p2 < {11'd0, nsum});

  assign b   = cmd.use_held ? hb : in_byte;
  assign lst = cmd.use_held ? hl : in_last;

  always_comb begin
    pos_inc    = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;
    idx        = pos[4:0];
    phase_next = phase;
    pos_next   = pos_inc;
    ch_next    = ch;
    fr_next    = fr;
    sk_next    = sk;
    tot_next   = tot;
    gn_next    = gn;
    cnt_next   = cnt;
    pk_next    = pk;
    pl_next    = pl;
    llo_next   = llo;
    ferr_next  = ferr;
    kind       = KIND_HEADER;
    err        = E_NONE;
    stat       = ST_RUN;
    pend       = 1'b0;
    hd         = 1'b0;
    len        = {b, llo};
    g          = '0;
    if (phase == PH_ERROR) begin
      kind = KIND_IGNORED;
    end else if (pos_inc > max_bytes) begin
      err = E_OVERSIZE;
    end else begin
      unique case (phase)
        PH_HEADER: begin
          if (lst && pos_inc < HEADER_LEN) begin
            err = E_SHORT;
          end else begin
            priority if (idx < 5'd4) begin
              if (b != MAGIC[idx[1:0]]) err = E_MAGIC;
            end else if (idx == 5'd4) begin
              if (b != 8'd1) err = E_VERSION;
            end else if (idx == 5'd5) begin
              if (b != 8'd1 && b != 8'd2) err = E_CHANNELS;
              else ch_next = b[1:0];
            end else if (idx < 5'd8) begin
              if (b != 8'd0) err = E_RESERVED;
            end else if (idx < 5'd12) begin
              if (b != rate[{idx[1:0], 3'b000} +: 8]) err = E_RATE;
            end else if (idx == 5'd12) begin
              fr_next = {8'd0, b};
            end else if (idx == 5'd13) begin
              fr_next = {b, fr[7:0]};
              if (!frame_ok(fr_next)) err = E_LIMITS;
            end else if (idx == 5'd14) begin
              sk_next = {8'd0, b};
            end else if (idx == 5'd15) begin
              sk_next = {b, sk[7:0]};
              if (sk_next > max_skip) err = E_LIMITS;
            end else if (idx < 5'd20) begin
              tot_next[{idx[1:0], 3'b000} +: 8] = tot[{idx[1:0], 3'b000} +: 8] | b;
              if (idx == 5'd19 && (tot_next == 32'd0 || tot_next > max_total))
                err = E_LIMITS;
            end else if (idx == 5'd20) begin
              gn_next = {8'd0, b};
            end else if (idx == 5'd21) begin
              g = {b, gn[7:0]};
              if (g < min_gain) g = min_gain;
              if (g > 16'sd0) g = 16'sd0;
              gn_next = g;
            end else begin
              cnt_next[{idx[1:0] + 2'd2, 3'b000} +: 8] =
                cnt[{idx[1:0] + 2'd2, 3'b000} +: 8] | b;
              if (idx == 5'd25) begin
                if (!cnt_ok) err = E_COUNT;
                else pk_next = cnt_next;
              end
            end
            if (err == E_NONE && idx == 5'd25) begin
              hd         = 1'b1;
              phase_next = PH_LEN_LO;
              if (lst) err = E_TRUNCATED;
            end
          end
        end
        PH_LEN_LO: begin
          kind       = KIND_LENGTH;
          llo_next   = b;
          phase_next = PH_LEN_HI;
          if (lst) err = E_TRUNCATED;
        end
        PH_LEN_HI: begin
          kind = KIND_LENGTH;
          if (len == 16'd0 || len > max_pkt) begin
            err = E_LENGTH;
          end else begin
            pl_next    = len;
            phase_next = PH_PAYLOAD;
            if (lst) err = E_TRUNCATED;
          end
        end
        PH_PAYLOAD: begin
          kind    = KIND_PAYLOAD;
          pl_next = pl - 16'd1;
          if (pl_next == 16'd0) begin
            pend       = 1'b1;
            pk_next    = pk - 32'd1;
            phase_next = (pk_next == 32'd0) ? PH_DONE : PH_LEN_LO;
          end
          if (lst) begin
            if (phase_next == PH_DONE) stat = ST_ACCEPTED;
            else err = E_TRUNCATED;
          end
        end
        PH_DONE: err = E_TRAILING;
        PH_ERROR: ;
        default: ;
      endcase
    end
    if (err != E_NONE) begin
      ferr_next  = err;
      phase_next = PH_ERROR;
    end
    if (phase_next == PH_ERROR) begin
      kind = KIND_IGNORED;
      stat = ST_REJECTED;
      pend = 1'b0;
    end
    show = phase_next == PH_LEN_LO || phase_next == PH_LEN_HI ||
           phase_next == PH_PAYLOAD || phase_next == PH_DONE;
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      byte_kind     <= kind;
      payload_byte  <= (kind == KIND_PAYLOAD) ? b : 8'd0;
      packet_end    <= pend;
      header_done   <= hd;
      channel_count <= show ? ch_next : 2'd0;
      frame_size    <= show ? fr_next[11:0] : 12'd0;
      skip_samples  <= show ? sk_next : 16'd0;
      sample_total  <= show ? tot_next : 32'd0;
      gain          <= show ? gn_next : 16'sd0;
      packet_total  <= show ? cnt_next : 32'd0;
      status        <= stat;
      error_code    <= (phase_next == PH_ERROR) ? ferr_next : E_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.step && lst)) begin
      phase <= PH_HEADER;
      pos   <= '0;
      ch    <= '0;
      fr    <= '0;
      sk    <= '0;
      tot   <= '0;
      gn    <= '0;
      cnt   <= '0;
      pk    <= '0;
      pl    <= '0;
      llo   <= '0;
      ferr  <= E_NONE;
    end else if (cmd.step) begin
      phase <= phase_next;
      pos   <= pos_next;
      ch    <= ch_next;
      fr    <= fr_next;
      sk    <= sk_next;
      tot   <= tot_next;
      gn    <= gn_next;
      cnt   <= cnt_next;
      pk    <= pk_next;
      pl    <= pl_next;
      llo   <= llo_next;
      ferr  <= ferr_next;
    end
  end

endmodule

### hw/rtl/scsp_ctrl.sv
// Parser controller: handshakes and the S_MUL/S_CHK packet count check.
// Depends on scsp_pkg.
module scsp_ctrl
  import scsp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [1:0] {S_IN, S_MUL, S_CHK} state_t;

  state_t state;
  logic   slot_free, take;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = state == S_IN && slot_free;
  assign take      = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IN: begin
        cmd.capture = take && st.count_byte;
        cmd.step    = take && !st.count_byte;
      end
      S_MUL: cmd.mul = 1'b1;
      S_CHK: begin
        cmd.use_held = 1'b1;
        cmd.step     = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IN;
      out_valid <= 1'b0;
    end else begin
      if (cmd.step) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IN:  if (cmd.capture) state <= S_MUL;
        S_MUL: state <= S_CHK;
        S_CHK: if (cmd.step) state <= S_IN;
        default: state <= S_IN;
      endcase
    end
  end

endmodule

### hw/rtl/song_container_stream_parser_unit.sv
// Song container stream parser, top level.
// Result registered in the cycle after the byte transfer; the last
// header byte waits for the count multiply (S_MUL) and compare (S_CHK).
// Throughput: one byte per cycle unless stalled or in the count check.
// Reset: synchronous rst restores the default registers and parser state.
module song_container_stream_parser_unit
  import scsp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  scsp_byte_if.sink   stream,
  scsp_res_if.source  result,
  scsp_cfg_if.sink    cfg
);

  cmd_t  cmd;
  stat_t st;

  assign cfg.ready = 1'b1;

  scsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stream.valid),
    .in_ready  (stream.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .st        (st),
    .cmd       (cmd)
  );

  scsp_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .in_byte       (stream.data_byte),
    .in_last       (stream.last),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .byte_kind     (result.byte_kind),
    .payload_byte  (result.payload_byte),
    .packet_end    (result.packet_end),
    .header_done   (result.header_done),
    .channel_count (result.channel_count),
    .frame_size    (result.frame_size),
    .skip_samples  (result.skip_samples),
    .sample_total  (result.sample_total),
    .gain          (result.gain),
    .packet_total  (result.packet_total),
    .status        (result.status),
    .error_code    (result.error_code)
  );

endmodule

### hw/rtl/scsp_checker.sv
// Port-level checks of the parser and their bind to the top level.
// Depends on scsp_pkg.
module scsp_checker
  import scsp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] byte_kind,
  input logic       packet_end,
  input logic       header_done,
  input logic [1:0] status,
  input logic [3:0] error_code
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_REJECTED |-> error_code != E_NONE && byte_kind == KIND_IGNORED)
    else $error("reject without error code");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ACCEPTED |-> packet_end && byte_kind == KIND_PAYLOAD)
    else $error("accept not on final payload byte");

  a_hdr: assert property (@(posedge clk) disable iff (rst)
    out_valid && header_done |-> byte_kind == KIND_HEADER || byte_kind == KIND_IGNORED)
    else $error("header_done on non-header byte");

endmodule

bind song_container_stream_parser_unit scsp_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .byte_kind   (result.byte_kind),
  .packet_end  (result.packet_end),
  .header_done (result.header_done),
  .status      (result.status),
  .error_code  (result.error_code)
);
